/* hdl/tte_pkg.sv */
// types and constants shared by the timer table engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tte_pkg;

  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned RES_CNT_W = 5;

  typedef enum logic [2:0] {
    FN_CREATE    = 3'd0,
    FN_START     = 3'd1,
    FN_STOP      = 3'd2,
    FN_CHECK     = 3'd3,
    FN_GROUP_STP = 3'd4,
    FN_OWNER_STP = 3'd5,
    FN_CLEAR     = 3'd6,
    FN_TICK      = 3'd7
  } func_t;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  typedef struct packed {
    logic [7:0]  owner;
    logic [15:0] timer_id;
    logic [7:0]  group;
    logic [31:0] user_data;
    logic        rpt;
    logic        active;
    logic [23:0] period;
    logic [31:0] stop_count;
    logic [39:0] deadline;
    logic [7:0]  dest;
  } entry_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  owner;
    logic [15:0] timer_id;
    logic [7:0]  group;
    logic [31:0] user_data;
    logic        rpt;
    logic [23:0] period;
    logic [7:0]  dest;
    logic [31:0] count;
  } cmd_t;

  typedef struct packed {
    entry_t upd;
    logic   we;
    logic   match;
    logic   free;
    logic   chk_hit;
    logic   emit;
  } step_t;

endpackage
`default_nettype wire

/* hdl/tte_entry_unit.sv */
// shared per-entry unit: applies the current command to one table entry
// depends on tte_pkg
`timescale 1ns / 1ps
`default_nettype none
module tte_entry_unit
  import tte_pkg::*;
(
  input  entry_t      ent,
  input  cmd_t        cmd,
  input  logic [39:0] now,
  input  logic        found,
  output step_t       res
);

  logic [39:0] reload;
  logic        match;
  entry_t      halted;

  assign reload = now + {16'd0, ent.period};
  assign match  = (ent.timer_id == cmd.timer_id) && (ent.owner == cmd.owner);

  always_comb begin
    halted = ent;
    halted.active = 1'b0;
    halted.stop_count = ent.stop_count + 32'd1;
  end

  always_comb begin
    res = '0;
    res.upd = ent;
    res.match = match;
    res.free = (ent.timer_id == 16'd0);
    res.chk_hit = match && (ent.stop_count == cmd.count);
    unique case (cmd.func)
      FN_START: begin
        if (match && !found) begin
          res.upd.deadline = reload;
          res.upd.active = 1'b1;
          res.we = 1'b1;
        end
      end
      FN_STOP: begin
        if (match && !found) begin
          res.upd = halted;
          res.we = 1'b1;
        end
      end
      FN_GROUP_STP: begin
        if (ent.group == cmd.group && ent.owner == cmd.owner) begin
          res.upd = halted;
          res.we = 1'b1;
        end
      end
      FN_OWNER_STP: begin
        if (ent.owner == cmd.owner) begin
          res.upd = halted;
          res.we = 1'b1;
        end
      end
      FN_CLEAR: begin
        res.upd = halted;
        res.upd.timer_id = 16'd0;
        res.we = 1'b1;
      end
      FN_TICK: begin
        if (ent.active && (now > ent.deadline)) begin
          if (ent.rpt) res.upd.deadline = reload;
          else res.upd.active = 1'b0;
          res.we = 1'b1;
          res.emit = (ent.dest != 8'd0);
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/tte_store.sv */
// timer table memory with per-entry valid bits; invalid entries read as zero
// depends on tte_pkg
`timescale 1ns / 1ps
`default_nettype none
module tte_store
  import tte_pkg::*;
#(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  entry_t             rd_data_r;
  logic               rd_ok_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (wr_en) valid_r[wr_addr] <= 1'b1;
      if (rd_en) rd_ok_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_ok_r ? rd_data_r : '0;

endmodule
`default_nettype wire

/* hdl/timer_table_engine_unit.sv */
// timer table engine top: command sequencer scanning the table one entry at a time
// depends on tte_pkg, tte_store, tte_entry_unit
//
// channel | direction | handshake          | payload
// in_     | input     | start && !busy     | in_func .. in_count
// out_    | output    | out_valid (strobe) | out_kind .. out_last
//
// each transaction reads every entry, then updates it through the single entry unit,
// in a read state and a process state per entry over the one memory port
// a final state writes the create entry or reports the status / last expiry
// reset (synchronous, rst_n low) clears the clock, the valid bits and control
// the receiver cannot stall: each result is on the out_ ports for one cycle
`timescale 1ns / 1ps
`default_nettype none
module timer_table_engine_unit
  import tte_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [7:0]  in_owner,
  input  logic [15:0] in_timer_id,
  input  logic [7:0]  in_group,
  input  logic [31:0] in_user_data,
  input  logic        in_repeat_req,
  input  logic [23:0] in_period_ms,
  input  logic [7:0]  in_dest_queue,
  input  logic [31:0] in_count,
  output logic        out_valid,
  output logic        out_kind,
  output logic        out_status,
  output logic [31:0] out_exp_user_data,
  output logic [7:0]  out_exp_group,
  output logic [15:0] out_exp_timer_id,
  output logic [31:0] out_exp_stop_count,
  output logic [7:0]  out_exp_dest,
  output logic        out_last
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_PROC = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  cmd_t   cmd_r;
  logic [39:0] now_r;
  logic [IW-1:0] idx_r;
  logic   found_r;     // a matching entry was seen earlier in the scan
  logic   chk_r;       // check command found an equal stop count
  logic   free_ok_r;   // a free entry was seen
  logic [IW-1:0] match_idx_r, free_idx_r;
  entry_t match_ent_r, free_ent_r;
  logic   hold_v_r;    // an expiry waits for the next one to learn if it is last
  entry_t hold_r;
  logic [RES_CNT_W-1:0] n_r;

  entry_t rd_data;
  step_t  step;
  logic   st_wr_en;
  logic [IW-1:0] st_wr_addr;
  entry_t st_wr_data;
  logic   idx_last;
  logic   accept;

  // output registers
  logic        ov_r, ok_r, os_r, ol_r;
  logic        ov_nxt;
  entry_t      oe_r;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign idx_last = (idx_r == IW'(ENTRIES - 1));

  tte_store #(.ENTRIES(ENTRIES), .IW(IW)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (state_r == S_RD),
    .rd_addr (idx_r),
    .rd_data (rd_data),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data)
  );

  tte_entry_unit u_unit (
    .ent   (rd_data),
    .cmd   (cmd_r),
    .now   (now_r),
    .found (found_r),
    .res   (step)
  );

  // create entry built from the scan results
  entry_t  cr_ent;
  logic    cr_ok;
  logic [IW-1:0] cr_idx;
  always_comb begin
    cr_ok  = (cmd_r.timer_id != 16'd0) && (found_r || free_ok_r);
    cr_idx = found_r ? match_idx_r : free_idx_r;
    cr_ent = found_r ? match_ent_r : free_ent_r;
    if (!found_r) begin
      cr_ent.owner    = cmd_r.owner;
      cr_ent.timer_id = cmd_r.timer_id;
      cr_ent.dest     = cmd_r.dest;
    end
    cr_ent.group     = cmd_r.group;
    cr_ent.user_data = cmd_r.user_data;
    cr_ent.rpt       = cmd_r.rpt;
    cr_ent.period    = cmd_r.period;
    cr_ent.active    = 1'b0;
    cr_ent.deadline  = 40'd0;
  end

  always_comb begin
    st_wr_en   = 1'b0;
    st_wr_addr = idx_r;
    st_wr_data = step.upd;
    if (state_r == S_PROC) begin
      st_wr_en = step.we;
    end else if (state_r == S_FIN && cmd_r.func == FN_CREATE) begin
      st_wr_en   = cr_ok;
      st_wr_addr = cr_idx;
      st_wr_data = cr_ent;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_RD;
      S_RD:   state_nxt = S_PROC;
      S_PROC: state_nxt = idx_last ? S_FIN : S_RD;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // strobe: a held expiry goes out when the next one arrives, the final result at the end
  always_comb begin
    ov_nxt = 1'b0;
    if (state_r == S_PROC && step.emit && n_r < RES_CNT_W'(MAX_RESULTS) && hold_v_r)
      ov_nxt = 1'b1;
    if (state_r == S_FIN && (cmd_r.func != FN_TICK || hold_v_r)) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      now_r     <= 40'd0;
      idx_r     <= '0;
      found_r   <= 1'b0;
      chk_r     <= 1'b0;
      free_ok_r <= 1'b0;
      hold_v_r  <= 1'b0;
      n_r       <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (accept) begin
        idx_r     <= '0;
        found_r   <= 1'b0;
        chk_r     <= 1'b0;
        free_ok_r <= 1'b0;
        hold_v_r  <= 1'b0;
        n_r       <= '0;
        if (func_t'(in_func) == FN_TICK) now_r <= now_r + 40'd1;
      end
      if (state_r == S_PROC) begin
        if (!idx_last) idx_r <= idx_r + IW'(1);
        if (step.match) found_r <= 1'b1;
        if (step.chk_hit) chk_r <= 1'b1;
        if (step.free) free_ok_r <= 1'b1;
        if (step.emit && n_r < RES_CNT_W'(MAX_RESULTS)) begin
          n_r      <= n_r + RES_CNT_W'(1);
          hold_v_r <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.func      <= func_t'(in_func);
      cmd_r.owner     <= in_owner;
      cmd_r.timer_id  <= in_timer_id;
      cmd_r.group     <= in_group;
      cmd_r.user_data <= in_user_data;
      cmd_r.rpt       <= in_repeat_req;
      cmd_r.period    <= in_period_ms;
      cmd_r.dest      <= in_dest_queue;
      cmd_r.count     <= in_count;
    end
    if (state_r == S_PROC) begin
      if (step.match && !found_r) begin
        match_idx_r <= idx_r;
        match_ent_r <= rd_data;
      end
      if (step.free && !free_ok_r) begin
        free_idx_r <= idx_r;
        free_ent_r <= rd_data;
      end
      if (step.emit && n_r < RES_CNT_W'(MAX_RESULTS)) begin
        hold_r <= rd_data;
        ok_r <= KIND_EXPIRY;
        os_r <= ST_OK;
        oe_r <= hold_r;
        ol_r <= 1'b0;
      end
    end
    if (state_r == S_FIN) begin
      ol_r <= 1'b1;
      if (cmd_r.func == FN_TICK) begin
        ok_r <= KIND_EXPIRY;
        os_r <= ST_OK;
        oe_r <= hold_r;
      end else begin
        ok_r <= KIND_STATUS;
        oe_r <= '0;
        priority case (cmd_r.func)
          FN_CREATE: os_r <= cr_ok ? ST_OK : ST_ERR;
          FN_CHECK:  os_r <= chk_r ? ST_OK : ST_ERR;
          default:   os_r <= ST_OK;
        endcase
      end
    end
  end

  assign out_valid          = ov_r;
  assign out_kind           = ok_r;
  assign out_status         = os_r;
  assign out_exp_user_data  = oe_r.user_data;
  assign out_exp_group      = oe_r.group;
  assign out_exp_timer_id   = oe_r.timer_id;
  assign out_exp_stop_count = oe_r.stop_count;
  assign out_exp_dest       = oe_r.dest;
  assign out_last           = ol_r;

`ifndef ASSERT_OFF
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result outside a transaction");
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_STATUS) |-> out_last)
    else $error("status result not last");
  a_exp_dest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_EXPIRY) |-> (out_exp_dest != 8'd0))
    else $error("expiry without destination");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy) else $error("last result while busy");
`endif

endmodule
`default_nettype wire

/* tb/tb_timer_table_engine_unit.sv */
// testbench for timer_table_engine_unit: directed table, filled-table phase, random commands
// depends on tte_pkg and the timer_table_engine_unit rtl
`timescale 1ns / 1ps
`default_nettype none
module tb_timer_table_engine_unit;
  import tte_pkg::*;

  localparam int NUM_ENTRIES = 16;
  localparam int SCAN_CYCLES = 2 * NUM_ENTRIES + 2;
  localparam int RAND_ITEMS = 100;
  localparam int CALM_ITEMS = 30;

  // one result transaction as seen on the out_ ports
  typedef struct packed {
    logic        kind;
    logic        status;
    logic [31:0] user_data;
    logic [7:0]  group;
    logic [15:0] timer_id;
    logic [31:0] stop_count;
    logic [7:0]  dest;
    logic        last;
  } timer_result_t;

  // one row of the directed table; pinned rows carry a status read off by hand
  typedef struct {
    cmd_t c;
    bit   pinned;
    logic pin_status;
  } cmd_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_func;
  logic [7:0]  in_owner;
  logic [15:0] in_timer_id;
  logic [7:0]  in_group;
  logic [31:0] in_user_data;
  logic        in_repeat_req;
  logic [23:0] in_period_ms;
  logic [7:0]  in_dest_queue;
  logic [31:0] in_count;
  logic        out_valid;
  logic        out_kind;
  logic        out_status;
  logic [31:0] out_exp_user_data;
  logic [7:0]  out_exp_group;
  logic [15:0] out_exp_timer_id;
  logic [31:0] out_exp_stop_count;
  logic [7:0]  out_exp_dest;
  logic        out_last;

  timer_table_engine_unit #(.ENTRIES(NUM_ENTRIES)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_owner(in_owner), .in_timer_id(in_timer_id),
    .in_group(in_group), .in_user_data(in_user_data), .in_repeat_req(in_repeat_req),
    .in_period_ms(in_period_ms), .in_dest_queue(in_dest_queue), .in_count(in_count),
    .out_valid(out_valid), .out_kind(out_kind), .out_status(out_status),
    .out_exp_user_data(out_exp_user_data), .out_exp_group(out_exp_group),
    .out_exp_timer_id(out_exp_timer_id), .out_exp_stop_count(out_exp_stop_count),
    .out_exp_dest(out_exp_dest), .out_last(out_last)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // shadow copy of the timer table and the millisecond clock
  logic [39:0] now_ms;
  entry_t      shadow[NUM_ENTRIES];

  timer_result_t pending_results[$];
  int          err_cnt = 0;
  bit          idle_on = 1'b1;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic timer_result_t status_result(input logic st);
    timer_result_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void bump_stop(input int e);
    shadow[e].active = 1'b0;
    shadow[e].stop_count = shadow[e].stop_count + 32'd1;
  endfunction

  // advance the shadow table by one command and queue what it must produce
  function automatic void predict_table_step(input cmd_t c);
    int          hit;
    int          n;
    logic        st;
    timer_result_t r;
    hit = -1;
    n = 0;
    st = ST_OK;
    if (c.func == FN_TICK) begin
      now_ms = now_ms + 40'd1;
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        if (shadow[e].active && now_ms > shadow[e].deadline) begin
          if (shadow[e].rpt) shadow[e].deadline = now_ms + 40'(shadow[e].period);
          else shadow[e].active = 1'b0;
          if (shadow[e].dest != 8'd0 && n < MAX_RESULTS) begin
            r = '0;
            r.kind = KIND_EXPIRY;
            r.status = ST_OK;
            r.user_data = shadow[e].user_data;
            r.group = shadow[e].group;
            r.timer_id = shadow[e].timer_id;
            r.stop_count = shadow[e].stop_count;
            r.dest = shadow[e].dest;
            pending_results.push_back(r);
            n++;
          end
        end
      end
      // only the final expiry of a tick carries last
      if (n > 0) pending_results[pending_results.size() - 1].last = 1'b1;
      return;
    end
    case (c.func)
      FN_CREATE: begin
        if (c.timer_id == 16'd0) st = ST_ERR;
        else begin
          for (int e = 0; e < NUM_ENTRIES && hit < 0; e++)
            if (shadow[e].timer_id == c.timer_id && shadow[e].owner == c.owner) hit = e;
          if (hit < 0) begin
            for (int e = 0; e < NUM_ENTRIES && hit < 0; e++)
              if (shadow[e].timer_id == 16'd0) hit = e;
            if (hit >= 0) begin
              shadow[hit].owner = c.owner;
              shadow[hit].timer_id = c.timer_id;
              shadow[hit].dest = c.dest;
            end
          end
          if (hit < 0) st = ST_ERR;
          else begin
            shadow[hit].group = c.group;
            shadow[hit].user_data = c.user_data;
            shadow[hit].rpt = c.rpt;
            shadow[hit].active = 1'b0;
            shadow[hit].period = c.period;
            shadow[hit].deadline = '0;
          end
        end
      end
      FN_START: begin
        for (int e = 0; e < NUM_ENTRIES && hit < 0; e++)
          if (shadow[e].timer_id == c.timer_id && shadow[e].owner == c.owner) begin
            hit = e;
            shadow[e].deadline = now_ms + 40'(shadow[e].period);
            shadow[e].active = 1'b1;
          end
      end
      FN_STOP: begin
        for (int e = 0; e < NUM_ENTRIES && hit < 0; e++)
          if (shadow[e].timer_id == c.timer_id && shadow[e].owner == c.owner) begin
            hit = e;
            bump_stop(e);
          end
      end
      FN_CHECK: begin
        st = ST_ERR;
        for (int e = 0; e < NUM_ENTRIES; e++)
          if (shadow[e].timer_id == c.timer_id && shadow[e].owner == c.owner &&
              shadow[e].stop_count == c.count) st = ST_OK;
      end
      FN_GROUP_STP: begin
        for (int e = 0; e < NUM_ENTRIES; e++)
          if (shadow[e].group == c.group && shadow[e].owner == c.owner) bump_stop(e);
      end
      FN_OWNER_STP: begin
        for (int e = 0; e < NUM_ENTRIES; e++)
          if (shadow[e].owner == c.owner) bump_stop(e);
      end
      default: begin
        for (int e = 0; e < NUM_ENTRIES; e++) begin
          shadow[e].timer_id = 16'd0;
          bump_stop(e);
        end
      end
    endcase
    pending_results.push_back(status_result(st));
  endfunction

  function automatic cmd_t mk(input func_t f, input logic [7:0] own, input logic [15:0] tid,
                              input logic [7:0] grp, input logic [31:0] ud, input logic rpt,
                              input logic [23:0] per, input logic [7:0] dst,
                              input logic [31:0] cnt);
    cmd_t c;
    c.func = f; c.owner = own; c.timer_id = tid; c.group = grp; c.user_data = ud;
    c.rpt = rpt; c.period = per; c.dest = dst; c.count = cnt;
    return c;
  endfunction

  // random command, biased toward a small pool of owners and ids so entries get reused
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 38) c.func = FN_TICK;
    else if (pick < 58) c.func = FN_CREATE;
    else if (pick < 72) c.func = FN_START;
    else if (pick < 80) c.func = FN_STOP;
    else if (pick < 88) c.func = FN_CHECK;
    else if (pick < 93) c.func = FN_GROUP_STP;
    else if (pick < 97) c.func = FN_OWNER_STP;
    else c.func = FN_CLEAR;
    c.owner = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    c.timer_id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
    c.group = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
    c.user_data = $urandom;
    c.rpt = 1'($urandom);
    c.period = ($urandom_range(0, 15) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4));
    c.dest = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom);
    c.count = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 3));
    return c;
  endfunction

  // present one command and hold it until the engine takes it
  task automatic send_cmd(input cmd_t c, input bit pinned = 1'b0, input logic pin_st = ST_OK);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= c.func;
    in_owner <= c.owner;
    in_timer_id <= c.timer_id;
    in_group <= c.group;
    in_user_data <= c.user_data;
    in_repeat_req <= c.rpt;
    in_period_ms <= c.period;
    in_dest_queue <= c.dest;
    in_count <= c.count;
    do @(posedge clk); while (busy);
    predict_table_step(c);
    // hand-read status replaces the predicted one on pinned rows
    if (pinned) pending_results[pending_results.size() - 1] = status_result(pin_st);
  endtask

  // results are strobed for one cycle and cannot be held off
  always @(posedge clk) begin
    timer_result_t got, want;
    if (rst_n && out_valid) begin
      got = {out_kind, out_status, out_exp_user_data, out_exp_group, out_exp_timer_id,
             out_exp_stop_count, out_exp_dest, out_last};
      if (pending_results.size() == 0) report("result transaction with nothing expected");
      else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind) report($sformatf("kind %b want %b", got.kind, want.kind));
        if (got.status !== want.status)
          report($sformatf("status %b want %b", got.status, want.status));
        if (got.user_data !== want.user_data)
          report($sformatf("user_data %h want %h", got.user_data, want.user_data));
        if (got.group !== want.group)
          report($sformatf("group %h want %h", got.group, want.group));
        if (got.timer_id !== want.timer_id)
          report($sformatf("timer_id %h want %h", got.timer_id, want.timer_id));
        if (got.stop_count !== want.stop_count)
          report($sformatf("stop_count %h want %h", got.stop_count, want.stop_count));
        if (got.dest !== want.dest)
          report($sformatf("dest %h want %h", got.dest, want.dest));
        if (got.last !== want.last) report($sformatf("last %b want %b", got.last, want.last));
      end
    end
  end

  // hard stop in case the engine hangs
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    cmd_row_t rows[$];
    cmd_row_t row;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FN_TICK;
    in_owner = '0;
    in_timer_id = '0;
    in_group = '0;
    in_user_data = '0;
    in_repeat_req = 1'b0;
    in_period_ms = '0;
    in_dest_queue = '0;
    in_count = '0;
    now_ms = '0;
    for (int e = 0; e < NUM_ENTRIES; e++) shadow[e] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: after reset, extremes, error codes, every command
    row.pinned = 1'b0;
    row.pin_status = ST_OK;
    // id zero addresses a free entry, stop count zero after reset
    row.c = mk(FN_CHECK, 8'd0, 16'd0, 8'd0, 32'd0, 1'b0, 24'd0, 8'd0, 32'd0);
    row.pinned = 1'b1; row.pin_status = ST_OK; rows.push_back(row);
    row.c = mk(FN_CHECK, 8'd0, 16'd0, 8'd0, 32'd0, 1'b0, 24'd0, 8'd0, 32'd1);
    row.pin_status = ST_ERR; rows.push_back(row);
    // create with id zero is refused
    row.c = mk(FN_CREATE, 8'd3, 16'd0, 8'd1, 32'd5, 1'b0, 24'd2, 8'd4, 32'd0);
    rows.push_back(row);
    row.c = mk(FN_CREATE, 8'hFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 24'd0, 8'hFF,
               32'hFFFF_FFFF);
    row.pin_status = ST_OK; rows.push_back(row);
    row.c = mk(FN_START, 8'hFF, 16'hFFFF, 8'd0, 32'd0, 1'b0, 24'd0, 8'd0, 32'd0);
    rows.push_back(row);
    row.pinned = 1'b0;
    // repeat with zero period expires on every tick
    row.c = mk(FN_TICK, 8'd0, 16'd0, 8'd0, 32'd0, 1'b0, 24'd0, 8'd0, 32'd0);
    rows.push_back(row); rows.push_back(row);
    // one-shot with destination zero expires silently
    row.c = mk(FN_CREATE, 8'd1, 16'd1, 8'd2, 32'h1234_5678, 1'b0, 24'd3, 8'd0, 32'd0);
    rows.push_back(row);
    row.c = mk(FN_START, 8'd1, 16'd1, 8'd0, 32'd0, 1'b0, 24'd0, 8'd0, 32'd0);
    rows.push_back(row);
    row.c = mk(FN_CREATE, 8'd2, 16'd5, 8'd7, 32'hA5A5_5A5A, 1'b0, 24'hFF_FFFF, 8'd1, 32'd0);
    rows.push_back(row);
    row.c = mk(FN_START, 8'd2, 16'd5, 8'd0, 32'd0, 1'b0, 24'd0, 8'd0, 32'd0);
    rows.push_back(row);
    row.c = mk(FN_TICK, 8'd0, 16'd0, 8'd0, 32'd0, 1'b0, 24'd0, 8'd0, 32'd0);
    for (int i = 0; i < 5; i++) rows.push_back(row);
    row.c = mk(FN_STOP, 8'hFF, 16'hFFFF, 8'd0, 32'd0, 1'b0, 24'd0, 8'd0, 32'd0);
    row.pinned = 1'b1; row.pin_status = ST_OK; rows.push_back(row);
    row.c = mk(FN_CHECK, 8'hFF, 16'hFFFF, 8'd0, 32'd0, 1'b0, 24'd0, 8'd0, 32'd1);
    rows.push_back(row);
    row.c = mk(FN_GROUP_STP, 8'd1, 16'd0, 8'd2, 32'd0, 1'b0, 24'd0, 8'd0, 32'd0);
    rows.push_back(row);
    row.c = mk(FN_OWNER_STP, 8'd2, 16'd0, 8'd0, 32'd0, 1'b0, 24'd0, 8'd0, 32'd0);
    rows.push_back(row);
    row.pinned = 1'b0;
    row.c = mk(FN_CHECK, 8'd2, 16'd5, 8'd0, 32'd0, 1'b0, 24'd0, 8'd0, 32'd1);
    rows.push_back(row);
    row.c = mk(FN_CLEAR, 8'd0, 16'd0, 8'd0, 32'd0, 1'b0, 24'd0, 8'd0, 32'd0);
    rows.push_back(row);
    row.c = mk(FN_TICK, 8'd0, 16'd0, 8'd0, 32'd0, 1'b0, 24'd0, 8'd0, 32'd0);
    rows.push_back(row);
    foreach (rows[i]) send_cmd(rows[i].c, rows[i].pinned, rows[i].pin_status);

    // fill every slot with a zero-period repeat timer so one tick gives a full burst
    for (int i = 1; i <= NUM_ENTRIES; i++)
      send_cmd(mk(FN_CREATE, 8'd9, 16'(i), 8'(i % 3), $urandom, 1'b1, 24'd0, 8'(i), 32'd0));
    for (int i = 1; i <= NUM_ENTRIES; i++)
      send_cmd(mk(FN_START, 8'd9, 16'(i), 8'd0, 32'd0, 1'b0, 24'd0, 8'd0, 32'd0));
    repeat (2) send_cmd(mk(FN_TICK, 8'd0, 16'd0, 8'd0, 32'd0, 1'b0, 24'd0, 8'd0, 32'd0));
    // table full: a new id is refused
    send_cmd(mk(FN_CREATE, 8'd9, 16'd100, 8'd0, 32'd0, 1'b0, 24'd0, 8'd1, 32'd0),
             1'b1, ST_ERR);
    send_cmd(mk(FN_GROUP_STP, 8'd9, 16'd0, 8'd1, 32'd0, 1'b0, 24'd0, 8'd0, 32'd0));
    send_cmd(mk(FN_TICK, 8'd0, 16'd0, 8'd0, 32'd0, 1'b0, 24'd0, 8'd0, 32'd0));
    send_cmd(mk(FN_CLEAR, 8'd0, 16'd0, 8'd0, 32'd0, 1'b0, 24'd0, 8'd0, 32'd0));

    // random commands, the tail runs back to back
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS - CALM_ITEMS) idle_on = 1'b0;
      send_cmd(rand_cmd());
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * SCAN_CYCLES) @(posedge clk);
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
